/* hw/rtl/fdl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared constants, register indexes and types of the fractional delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int MAX_DELAY_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int LEN_W      = 13;  // delay_length register
  localparam int COEF_W     = 33;  // signed Q4.28 coefficients (sign, 4 integer bits, 28 fraction bits)
  localparam int FRAC_BITS  = 28;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam int FIFO_DEPTH = 4;   // power of two
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_LENGTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALLPASS_ENABLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1        = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2        = 3'd6;

  typedef logic signed [COEF_W-1:0] coef_t;

  // per-stage control travelling with a sample
  typedef struct packed {
    logic valid;
    logic last;
  } fdl_ctl_t;

endpackage

/* hw/rtl/fdl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/fdl_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_delay
// Circular integer delay line with fill mark; registers one stage of samples.
// ----------------------------------------------------------------------------
module fdl_delay
  import fdl_pkg::*;
#(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LW = $clog2(MAX_DELAY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic                          last,
  input  logic [LW-1:0]                 len,
  input  logic                          ptr_clear,
  output fdl_ctl_t                      s1_ctl,
  output logic signed [SAMPLE_BITS-1:0] s1_v
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

  logic [AW-1:0]                 ptr_r, ptr_nxt;
  logic [LW-1:0]                 fill_r, fill_nxt;
  logic [AW-1:0]                 rp;
  logic [LW-1:0]                 rp_inc;
  logic                          active;
  logic                          hit;
  logic [SAMPLE_BITS-1:0]        ram_q;
  fdl_ctl_t                      s1_ctl_r;
  logic signed [SAMPLE_BITS-1:0] s1_x_r;
  logic                          s1_bypass_r;
  logic                          s1_hit_r;

  always_comb begin
    rp       = (LW'(ptr_r) < len) ? ptr_r : '0;
    rp_inc   = LW'(rp) + LW'(1);
    active   = accept && (len != '0);
    // entries below the fill mark have been written since reset
    hit      = LW'(rp) < fill_r;
    ptr_nxt  = (rp_inc >= len) ? '0 : rp_inc[AW-1:0];
    fill_nxt = (rp_inc > fill_r) ? rp_inc : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (ptr_clear) begin
      ptr_r <= '0;
    end else if (active) begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  fdl_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_DELAY)
  ) u_fdl_ram (
    .clk    (clk),
    .wr_en  (active),
    .wr_addr(rp),
    .wr_data(x),
    .rd_en  (active),
    .rd_addr(rp),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r.valid <= accept;
      s1_ctl_r.last  <= last;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r      <= x;
    s1_bypass_r <= (len == '0);
    s1_hit_r    <= hit;
  end

  assign s1_ctl = s1_ctl_r;
  assign s1_v   = s1_bypass_r ? s1_x_r :
                  (s1_hit_r ? $signed(ram_q) : '0);

endmodule

/* hw/rtl/fdl_biquad.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_biquad
// Direct-form-I allpass biquad: feedforward products, then feedback, round
// and saturate into the result; with en low the sample passes through unfiltered.
// ----------------------------------------------------------------------------
module fdl_biquad
  import fdl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  coef_t                         coef_b0,
  input  coef_t                         coef_b1,
  input  coef_t                         coef_b2,
  input  coef_t                         coef_a1,
  input  coef_t                         coef_a2,
  input  fdl_ctl_t                      in_ctl,
  input  logic signed [SAMPLE_BITS-1:0] v,
  output fdl_ctl_t                      res_ctl,
  output logic signed [SAMPLE_BITS-1:0] res_y
);

  localparam int PW = SAMPLE_BITS + COEF_W;
  localparam int SW = PW + 3;
  localparam int QW = SW - FRAC_BITS;
  localparam logic signed [SW-1:0] RND =
    {{(SW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [QW-1:0] Q_MAX =
    {{(QW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN =
    {{(QW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x1_r, x2_r, y1_r, y2_r;
  logic signed [SAMPLE_BITS-1:0] v2_r;
  logic signed [PW-1:0]          p0_nxt, p1_nxt, p2_nxt;
  logic signed [PW-1:0]          p0_r, p1_r, p2_r;
  logic signed [PW-1:0]          fb1, fb2;
  logic signed [SW-1:0]          acc;
  logic signed [QW-1:0]          q;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  fdl_ctl_t                      s2_ctl_r;

  // feedforward stage
  always_comb begin
    p0_nxt = coef_b0 * v;
    p1_nxt = coef_b1 * x1_r;
    p2_nxt = coef_b2 * x2_r;
  end

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
    v2_r <= v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      x1_r     <= '0;
      x2_r     <= '0;
    end else begin
      s2_ctl_r <= in_ctl;
      if (in_ctl.valid) begin
        if (en) begin
          x1_r <= v;
          x2_r <= x1_r;
        end else begin
          x1_r <= '0;
          x2_r <= '0;
        end
      end
    end
  end

  // feedback, rounding half up, saturation: one result per cycle
  always_comb begin
    fb1 = coef_a1 * y1_r;
    fb2 = coef_a2 * y2_r;
    acc = SW'(p0_r) + SW'(p1_r) + SW'(p2_r) - SW'(fb1) - SW'(fb2) + RND;
    q   = $signed(acc[SW-1:FRAC_BITS]);
    if (q > Q_MAX) begin
      y_sat = Q_MAX[SAMPLE_BITS-1:0];
    end else if (q < Q_MIN) begin
      y_sat = Q_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_r <= '0;
      y2_r <= '0;
    end else if (s2_ctl_r.valid) begin
      if (en) begin
        y1_r <= y_sat;
        y2_r <= y1_r;
      end else begin
        y1_r <= '0;
        y2_r <= '0;
      end
    end
  end

  assign res_ctl = s2_ctl_r;
  assign res_y   = en ? y_sat : v2_r;

endmodule

/* hw/rtl/fdl_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_out_fifo
// Small result queue; its entries are the result registers of the block.
// ----------------------------------------------------------------------------
module fdl_out_fifo
  import fdl_pkg::*;
#(
  parameter int WIDTH = SAMPLE_BITS_DEF + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic               valid,
  output logic [WIDTH-1:0]   data,
  output logic [FIFO_CW-1:0] count
);

  logic [WIDTH-1:0]   entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  assign valid = (count_r != '0);
  assign data  = entry_r[rd_ptr_r];
  assign count = count_r;

endmodule

/* hw/rtl/fractional_delay_line_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_line_core
// Pipeline: delay stage, biquad stage, then the result queue that drives out_tvalid.
// Throughput: one sample per cycle while the result queue has room (in_tready); the
// allpass feedback (a1/a2 multiply, sum, round, saturate) is combinational ahead of the result queue.
// Reset: synchronous; delay memory entries at or above a fill mark read as
// zero, so no clearing pass is needed and the block is ready after reset.
// ----------------------------------------------------------------------------
module fractional_delay_line_core
  import fdl_pkg::*;
#(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  logic                  in_tlast,   // block_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  output logic                  out_tlast,  // block_last_out
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LW = $clog2(MAX_DELAY + 1);
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;

  logic [LEN_W-1:0] delay_length_r;
  logic             allpass_en_r;
  coef_t            coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;

  logic                          in_xfer;
  logic                          out_xfer;
  logic [LW-1:0]                 len_eff;
  logic                          ptr_clear;
  fdl_ctl_t                      s1_ctl;
  logic signed [SAMPLE_BITS-1:0] s1_v;
  fdl_ctl_t                      res_ctl;
  logic signed [SAMPLE_BITS-1:0] res_y;
  logic [SAMPLE_BITS:0]          fifo_data;
  logic [FIFO_CW-1:0]            fifo_count;
  logic [FIFO_CW-1:0]            in_flight;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_length_r <= '0;
      allpass_en_r   <= 1'b0;
      coef_b0_r      <= '0;
      coef_b1_r      <= '0;
      coef_b2_r      <= '0;
      coef_a1_r      <= '0;
      coef_a2_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DELAY_LENGTH:   delay_length_r <= cfg_wdata[LEN_W-1:0];
        REG_ALLPASS_ENABLE: allpass_en_r   <= cfg_wdata[0];
        REG_COEF_B0:        coef_b0_r      <= $signed(cfg_wdata);
        REG_COEF_B1:        coef_b1_r      <= $signed(cfg_wdata);
        REG_COEF_B2:        coef_b2_r      <= $signed(cfg_wdata);
        REG_COEF_A1:        coef_a1_r      <= $signed(cfg_wdata);
        REG_COEF_A2:        coef_a2_r      <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign ptr_clear = cfg_we && (cfg_addr == REG_DELAY_LENGTH);
  assign len_eff   = (CW'(delay_length_r) > CW'(MAX_DELAY)) ?
                     LW'(MAX_DELAY) : LW'(delay_length_r);

  // pipeline never stalls: admit only what the result queue can still hold
  assign in_flight = fifo_count + FIFO_CW'(s1_ctl.valid) + FIFO_CW'(res_ctl.valid);
  assign in_tready = in_flight < FIFO_CW'(FIFO_DEPTH);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  fdl_delay #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_fdl_delay (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_xfer),
    .x        ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .last     (in_tlast),
    .len      (len_eff),
    .ptr_clear(ptr_clear),
    .s1_ctl   (s1_ctl),
    .s1_v     (s1_v)
  );

  fdl_biquad #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_fdl_biquad (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (allpass_en_r),
    .coef_b0(coef_b0_r),
    .coef_b1(coef_b1_r),
    .coef_b2(coef_b2_r),
    .coef_a1(coef_a1_r),
    .coef_a2(coef_a2_r),
    .in_ctl (s1_ctl),
    .v      (s1_v),
    .res_ctl(res_ctl),
    .res_y  (res_y)
  );

  fdl_out_fifo #(
    .WIDTH(SAMPLE_BITS + 1)
  ) u_fdl_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_ctl.valid),
    .push_data({res_ctl.last, res_y}),
    .pop      (out_xfer),
    .valid    (out_tvalid),
    .data     (fifo_data),
    .count    (fifo_count)
  );

  assign out_tdata = TDATA_W'(fifo_data[SAMPLE_BITS-1:0]);
  assign out_tlast = fifo_data[SAMPLE_BITS];

endmodule

/* hw/rtl/fdl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_checker
// Port-level checks of the fractional delay line, bound to the top level.
// ----------------------------------------------------------------------------
module fdl_checker #(
  parameter int TDATA_W = 24
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast
);

  // nothing left over after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // no clearing pass: ready straight after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // every transfer in has out_tvalid high once it has passed the delay and biquad stages into the queue
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> ##2 out_tvalid)
    else $error("result missing after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind fractional_delay_line_core fdl_checker #(.TDATA_W(TDATA_W)) u_fdl_checker (.*);
